// ----- rtl/tagged_min_heap_merger_unit_macros.svh -----
// Assertion helpers for the checker file of the heap merger.
// Both sample on the rising edge of clk and are held off while rst_n is low.
`ifndef TAGGED_MIN_HEAP_MERGER_UNIT_MACROS_SVH
`define TAGGED_MIN_HEAP_MERGER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TMHM_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap merger check failed");

// Next-cycle implication.
`define TMHM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap merger check failed");

`endif

// ----- rtl/tmhm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tmhm_pkg;

    // Operation codes carried by an input transaction.
    typedef logic [1:0] op_t;
    localparam op_t OP_INSERT  = 2'd0;
    localparam op_t OP_REPLACE = 2'd1;
    localparam op_t OP_POP     = 2'd2;

    // Status codes returned with every result.
    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP_RD,
        S_UP_CMP,
        S_TOP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    // Which pair of heap slots the datapath reads.
    typedef enum logic [1:0] {
        RD_TOP,
        RD_UP,
        RD_DN
    } rd_sel_t;

    // What the datapath writes into the slot at the current index.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_MOVING,
        WR_PARENT,
        WR_CHILD
    } wr_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    start;
        status_t status_code;
        logic    insert_begin;
        logic    take_top;
        logic    up_move;
        logic    dn_move;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    load_result;
    } tmhm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic idx_zero;
        logic up_less;
        logic dn_leaf;
        logic dn_take;
    } tmhm_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tmhm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one operation per transaction.
interface tmhm_in_if
    import tmhm_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int TAG_BITS   = 3
);
    logic                         valid;
    logic                         ready;
    op_t                          op;
    logic signed [VALUE_BITS-1:0] new_value;
    logic [TAG_BITS-1:0]          source_tag;

    modport source (output valid, op, new_value, source_tag, input ready);
    modport sink   (input valid, op, new_value, source_tag, output ready);
endinterface

`default_nettype wire

// ----- rtl/tmhm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Output channel: one result per transaction.
interface tmhm_out_if
    import tmhm_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int TAG_BITS   = 3,
    parameter int COUNT_BITS = 5
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] top_value;
    logic [TAG_BITS-1:0]          top_tag;
    logic [COUNT_BITS-1:0]        entry_count;
    status_t                      status;

    modport source (output valid, top_value, top_tag, entry_count, status, input ready);
    modport sink   (input valid, top_value, top_tag, entry_count, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/tmhm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Generic RAM: one write port, two read ports with registered read data.
module tmhm_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr_a,
    output logic      [WIDTH-1:0] rd_data_a,
    input  wire logic [AW-1:0]    rd_addr_b,
    output logic      [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read; a read of the address written in the same cycle returns old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ----- rtl/tmhm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Heap datapath: slot store, moving entry, hole index, count and result registers.
module tmhm_datapath
    import tmhm_pkg::*;
#(
    parameter int HEAP_DEPTH = 16,
    parameter int VALUE_BITS = 32,
    parameter int TAG_BITS   = 3,
    localparam int CB        = $clog2(HEAP_DEPTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tmhm_cmd_t                    cmd,
    output tmhm_stat_t                        stat,
    input  wire op_t                          in_op,
    input  wire logic signed [VALUE_BITS-1:0] in_value,
    input  wire logic [TAG_BITS-1:0]          in_tag,
    output logic signed [VALUE_BITS-1:0]      out_value,
    output logic [TAG_BITS-1:0]               out_tag,
    output logic [CB-1:0]                     out_count,
    output status_t                           out_status
);

    localparam int IB = $clog2(HEAP_DEPTH);
    localparam int XB = IB + 2;
    localparam int EW = VALUE_BITS + TAG_BITS;

    op_t                          op_reg, op_next;
    logic signed [VALUE_BITS-1:0] mv_value_reg, mv_value_next;
    logic [TAG_BITS-1:0]          mv_tag_reg, mv_tag_next;
    logic [IB-1:0]                idx_reg, idx_next;
    logic [CB-1:0]                count_reg, count_next;
    logic signed [VALUE_BITS-1:0] top_value_reg, top_value_next;
    logic [TAG_BITS-1:0]          top_tag_reg, top_tag_next;
    status_t                      status_reg, status_next;
    logic signed [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic [TAG_BITS-1:0]          out_tag_reg, out_tag_next;
    logic [CB-1:0]                out_count_reg, out_count_next;
    status_t                      out_status_reg, out_status_next;

    logic [IB-1:0]                rd_addr_a, rd_addr_b, wr_addr;
    logic [EW-1:0]                rd_data_a, rd_data_b, wr_data;
    logic                         wr_en;
    logic signed [VALUE_BITS-1:0] rd_a_value, rd_b_value, child_value;
    logic [TAG_BITS-1:0]          rd_a_tag, rd_b_tag, child_tag;
    logic [XB-1:0]                left_x, right_x, count_x;
    logic [IB-1:0]                left_idx, right_idx, parent_idx, last_idx, child_idx;
    logic                         right_wins;

    // Slot store.
    tmhm_ram #(
        .WIDTH(EW),
        .DEPTH(HEAP_DEPTH)
    ) u_ram (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr_a(rd_addr_a),
        .rd_data_a(rd_data_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_b(rd_data_b)
    );

    // Neighbor indices of the hole.
    assign left_x     = XB'({idx_reg, 1'b1});
    assign right_x    = left_x + XB'(1);
    assign count_x    = XB'(count_reg);
    assign left_idx   = left_x[IB-1:0];
    assign right_idx  = right_x[IB-1:0];
    assign parent_idx = (idx_reg - IB'(1)) >> 1;
    assign last_idx   = IB'(count_reg - CB'(1));

    // Unpack the read data.
    assign rd_a_value = rd_data_a[EW-1:TAG_BITS];
    assign rd_a_tag   = rd_data_a[TAG_BITS-1:0];
    assign rd_b_value = rd_data_b[EW-1:TAG_BITS];
    assign rd_b_tag   = rd_data_b[TAG_BITS-1:0];

    // Smaller child; the left one wins a tie and a missing right child never wins.
    assign right_wins  = (right_x < count_x) && (rd_b_value < rd_a_value);
    assign child_value = right_wins ? rd_b_value : rd_a_value;
    assign child_tag   = right_wins ? rd_b_tag : rd_a_tag;
    assign child_idx   = right_wins ? right_idx : left_idx;

    // Read address selection.
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_TOP:
            begin
                rd_addr_a = '0;
                rd_addr_b = last_idx;
            end
            RD_UP:
            begin
                rd_addr_a = parent_idx;
                rd_addr_b = last_idx;
            end
            RD_DN:
            begin
                rd_addr_a = left_idx;
                rd_addr_b = right_idx;
            end
            default:
            begin
                rd_addr_a = left_idx;
                rd_addr_b = right_idx;
            end
        endcase
    end

    // Write into the hole.
    assign wr_addr = idx_reg;
    assign wr_en   = (cmd.wr_sel != WR_NONE);
    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_MOVING: wr_data = {mv_value_reg, mv_tag_reg};
            WR_PARENT: wr_data = rd_data_a;
            WR_CHILD:  wr_data = {child_value, child_tag};
            default:   wr_data = {mv_value_reg, mv_tag_reg};
        endcase
    end

    // Status toward the controller.
    assign stat.op       = op_reg;
    assign stat.full     = (count_reg == CB'(HEAP_DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.up_less  = (mv_value_reg < rd_a_value);
    assign stat.dn_leaf  = (left_x >= count_x);
    assign stat.dn_take  = (child_value < mv_value_reg);

    // Next-state logic of the datapath registers.
    always_comb
    begin
        op_next         = op_reg;
        mv_value_next   = mv_value_reg;
        mv_tag_next     = mv_tag_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        top_value_next  = top_value_reg;
        top_tag_next    = top_tag_reg;
        status_next     = status_reg;
        out_value_next  = out_value_reg;
        out_tag_next    = out_tag_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        if (cmd.capture)
        begin
            op_next       = in_op;
            mv_value_next = in_value;
            mv_tag_next   = in_tag;
        end
        if (cmd.start)
        begin
            top_value_next = '0;
            top_tag_next   = '0;
            status_next    = cmd.status_code;
        end
        if (cmd.insert_begin)
        begin
            idx_next   = IB'(count_reg);
            count_next = count_reg + CB'(1);
        end
        if (cmd.take_top)
        begin
            top_value_next = rd_a_value;
            top_tag_next   = rd_a_tag;
            idx_next       = '0;
            // A pop moves the last entry to the root.
            if (op_reg == OP_POP)
            begin
                mv_value_next = rd_b_value;
                mv_tag_next   = rd_b_tag;
                count_next    = count_reg - CB'(1);
            end
        end
        if (cmd.up_move)
        begin
            idx_next = parent_idx;
        end
        if (cmd.dn_move)
        begin
            idx_next = child_idx;
        end
        if (cmd.load_result)
        begin
            out_value_next  = top_value_reg;
            out_tag_next    = top_tag_reg;
            out_count_next  = count_reg;
            out_status_next = status_reg;
        end
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        mv_value_reg   <= mv_value_next;
        mv_tag_reg     <= mv_tag_next;
        idx_reg        <= idx_next;
        top_value_reg  <= top_value_next;
        top_tag_reg    <= top_tag_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_tag_reg    <= out_tag_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign out_value  = out_value_reg;
    assign out_tag    = out_tag_reg;
    assign out_count  = out_count_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

// ----- rtl/tmhm_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Controller: sequences decode, sift-up, sift-down and the result handoff.
module tmhm_controller
    import tmhm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output tmhm_cmd_t       cmd,
    input  wire tmhm_stat_t stat
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   is_insert, is_remove, can_insert, can_remove, out_free;

    assign is_insert  = (stat.op == OP_INSERT);
    assign is_remove  = (stat.op == OP_REPLACE) || (stat.op == OP_POP);
    assign can_insert = is_insert && !stat.full;
    assign can_remove = is_remove && !stat.empty;
    assign out_free   = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (can_insert)
                begin
                    state_next = S_UP_RD;
                end
                else if (can_remove)
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UP_RD:
            begin
                state_next = stat.idx_zero ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                state_next = stat.up_less ? S_UP_RD : S_DONE;
            end
            S_TOP:
            begin
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                state_next = stat.dn_leaf ? S_DONE : S_DN_CMP;
            end
            S_DN_CMP:
            begin
                state_next = stat.dn_take ? S_DN_RD : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd             = '0;
        cmd.status_code = ST_OK;
        cmd.rd_sel      = RD_DN;
        cmd.wr_sel      = WR_NONE;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                cmd.start = 1'b1;
                priority if (is_insert && stat.full)
                begin
                    cmd.status_code = ST_FULL;
                end
                else if (is_remove && stat.empty)
                begin
                    cmd.status_code = ST_EMPTY;
                end
                else
                begin
                    cmd.status_code = ST_OK;
                end
                cmd.insert_begin = can_insert;
                if (can_remove)
                begin
                    cmd.rd_sel = RD_TOP;
                end
            end
            S_UP_RD:
            begin
                if (stat.idx_zero)
                begin
                    cmd.wr_sel = WR_MOVING;
                end
                else
                begin
                    cmd.rd_sel = RD_UP;
                end
            end
            S_UP_CMP:
            begin
                // Pull the larger parent down into the hole, or settle the entry.
                if (stat.up_less)
                begin
                    cmd.wr_sel  = WR_PARENT;
                    cmd.up_move = 1'b1;
                end
                else
                begin
                    cmd.wr_sel = WR_MOVING;
                end
            end
            S_TOP:
            begin
                cmd.take_top = 1'b1;
            end
            S_DN_RD:
            begin
                if (stat.dn_leaf)
                begin
                    cmd.wr_sel = WR_MOVING;
                end
                else
                begin
                    cmd.rd_sel = RD_DN;
                end
            end
            S_DN_CMP:
            begin
                // Lift the smaller child into the hole, or settle the entry.
                if (stat.dn_take)
                begin
                    cmd.wr_sel  = WR_CHILD;
                    cmd.dn_move = 1'b1;
                end
                else
                begin
                    cmd.wr_sel = WR_MOVING;
                end
            end
            S_DONE:
            begin
                cmd.load_result = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Output valid flag: set when a result loads, cleared when it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/tagged_min_heap_merger_unit.sv -----
// Min-heap of (value, source tag) entries for merging sorted streams.
// The input channel carries one operation per transaction: insert, replace
// top or pop top. The output channel returns one result per transaction:
// the removed entry (zero for insert), the entry count after the operation
// and a status (ok, empty on replace or pop, full on insert).
// A rejected or ignored operation goes from decode straight to the done state;
// an insert sifts up from the new last slot, and a replace or pop takes the
// top and sifts down from the root. Each level of a sift reads the slot RAM
// and then compares and writes it; the slot RAM has one write port and two
// registered read ports.
// One operation is in flight at a time; the next one is accepted in the
// cycle after its predecessor's result is registered.
// Reset empties the heap at once; the slot RAM needs no clearing.
// The result sits in an output register; if the receiver stalls, a finished
// operation waits in the done state until the output register is free, and
// the block accepts the next transaction only after that result has loaded.
`timescale 1ns / 1ps
`default_nettype none

module tagged_min_heap_merger_unit
    import tmhm_pkg::*;
#(
    parameter int HEAP_DEPTH  = 16,
    parameter int NUM_SOURCES = 8,
    parameter int VALUE_BITS  = 32
) (
    input wire logic    clk,
    input wire logic    rst_n,
    tmhm_in_if.sink     in_ch,
    tmhm_out_if.source  out_ch
);

    localparam int TAG_BITS   = $clog2(NUM_SOURCES);
    localparam int COUNT_BITS = $clog2(HEAP_DEPTH + 1);

    tmhm_cmd_t  cmd;
    tmhm_stat_t stat;

    // Sequencer.
    tmhm_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Heap storage and arithmetic.
    tmhm_datapath #(
        .HEAP_DEPTH(HEAP_DEPTH),
        .VALUE_BITS(VALUE_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (in_ch.op),
        .in_value  (in_ch.new_value),
        .in_tag    (in_ch.source_tag),
        .out_value (out_ch.top_value),
        .out_tag   (out_ch.top_tag),
        .out_count (out_ch.entry_count),
        .out_status(out_ch.status)
    );

endmodule

`default_nettype wire

// ----- rtl/tmhm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "tagged_min_heap_merger_unit_macros.svh"

// Port-level checks of the heap merger.
module tmhm_checker
    import tmhm_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int TAG_BITS   = 3,
    parameter int COUNT_BITS = 5,
    parameter int HEAP_DEPTH = 16
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic signed [VALUE_BITS-1:0] top_value,
    input wire logic [TAG_BITS-1:0]          top_tag,
    input wire logic [COUNT_BITS-1:0]        entry_count,
    input wire status_t                      status
);

    // A result stays offered until it is taken.
    `TMHM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // The count never passes the heap depth.
    `TMHM_ASSERT(a_count_bound, out_valid, entry_count <= COUNT_BITS'(HEAP_DEPTH))

    // A rejected insert reports a full heap and no removed entry.
    `TMHM_ASSERT(a_full_result, out_valid && status == ST_FULL,
        entry_count == COUNT_BITS'(HEAP_DEPTH) && top_value == '0 && top_tag == '0)

    // A rejected removal reports an empty heap and no removed entry.
    `TMHM_ASSERT(a_empty_result, out_valid && status == ST_EMPTY,
        entry_count == '0 && top_value == '0 && top_tag == '0)

endmodule

bind tagged_min_heap_merger_unit tmhm_checker #(
    .VALUE_BITS(VALUE_BITS),
    .TAG_BITS  (TAG_BITS),
    .COUNT_BITS(COUNT_BITS),
    .HEAP_DEPTH(HEAP_DEPTH)
) u_tmhm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .top_value  (out_ch.top_value),
    .top_tag    (out_ch.top_tag),
    .entry_count(out_ch.entry_count),
    .status     (out_ch.status)
);

`default_nettype wire
